// ===== rtl/plrc_pkg.sv =====
// Shared types and constants for the programmable logic rule cell.
`default_nettype none

package plrc_pkg;

  localparam int unsigned NUM_SOURCES = 8;
  localparam int unsigned CountW      = 16;
  localparam int unsigned TimeW       = 32;
  localparam int unsigned CfgIndexW   = 4;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned MvW         = 15;

  typedef enum logic [4:0] {
    MODE_DIRECT     = 5'd0,
    MODE_DIRECT_INV = 5'd1,
    MODE_NOT        = 5'd2,
    MODE_AND        = 5'd3,
    MODE_OR         = 5'd4,
    MODE_NAND       = 5'd5,
    MODE_NOR        = 5'd6,
    MODE_XOR        = 5'd7,
    MODE_TOGGLE     = 5'd8,
    MODE_SR_LATCH   = 5'd9,
    MODE_FLASHER    = 5'd10,
    MODE_HAZARD     = 5'd11,
    MODE_THRESH     = 5'd12,
    MODE_THRESH_INV = 5'd13,
    MODE_HYSTERESIS = 5'd14,
    MODE_WATCHDOG   = 5'd15,
    MODE_NPRESS     = 5'd16,
    MODE_OFF        = 5'd17
  } plrc_mode_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_MODE         = 4'd0,
    CFG_SOURCE_COUNT = 4'd1,
    CFG_ON_TIME      = 4'd2,
    CFG_OFF_TIME     = 4'd3,
    CFG_WINDOW_TIME  = 4'd4,
    CFG_COUNT_LIMIT  = 4'd5,
    CFG_THRESH_LOW   = 4'd6,
    CFG_THRESH_HIGH  = 4'd7
  } plrc_cfg_idx_e;

  typedef struct packed {
    logic [4:0]               mode;
    logic [3:0]               source_count;
    logic [CountW-1:0]        on_time;
    logic [CountW-1:0]        off_time;
    logic [CountW-1:0]        window_time;
    logic [CountW-1:0]        count_limit;
    logic signed [CountW-1:0] thresh_low;
    logic signed [CountW-1:0] thresh_high;
  } plrc_cfg_t;

  typedef struct packed {
    logic              prev_source;
    logic              latch;
    logic              flash_on;
    logic [TimeW-1:0]  flash_stamp;
    logic              started;
    logic [CountW-1:0] hazard_cycles;
    logic [TimeW-1:0]  edge_stamp;
    logic [CountW-1:0] press_total;
    logic [TimeW-1:0]  pulse_until;
  } plrc_state_t;

  typedef struct packed {
    logic [TimeW-1:0]       now;
    logic [NUM_SOURCES-1:0] sources;
    logic                   second_source;
    logic [MvW-1:0]         millivolts;
    logic                   sample_ok;
  } plrc_item_t;

endpackage

`default_nettype wire

// ===== rtl/plrc_eval.sv =====
// Combinational rule evaluation: next rule state and output level for one tick.
`default_nettype none

module plrc_eval
  import plrc_pkg::*;
(
  input  plrc_cfg_t   cfg_i,
  input  plrc_state_t state_i,
  input  plrc_item_t  item_i,
  output plrc_state_t state_o,
  output logic        level_o
);

  logic [NUM_SOURCES-1:0] src_mask;
  logic                   s0;
  logic                   all_set;
  logic                   any_set;
  logic                   rise;
  logic [TimeW-1:0]       stamp;
  logic [CountW-1:0]      interval;
  logic                   flash_adv;
  logic                   hazard_done;
  logic signed [CountW:0] mv_s;
  logic signed [CountW:0] lo_s;
  logic signed [CountW:0] hi_s;
  logic [TimeW-1:0]       edge_new;
  logic [CountW-1:0]      press_new;
  logic                   press_expired;
  logic                   post_expired;
  logic [TimeW-1:0]       pulse_new;

  always_comb begin
    for (int i = 0; i < NUM_SOURCES; i++) begin
      src_mask[i] = (i < int'(cfg_i.source_count));
    end
  end

  assign s0      = item_i.sources[0];
  assign all_set = ((item_i.sources & src_mask) == src_mask);
  assign any_set = ((item_i.sources & src_mask) != '0);
  assign rise    = s0 & ~state_i.prev_source;

  // The flasher time base is taken from the first transfer after reset.
  assign stamp     = state_i.started ? state_i.flash_stamp : item_i.now;
  assign interval  = state_i.flash_on ? cfg_i.on_time : cfg_i.off_time;
  assign flash_adv = (interval != '0) &&
                     ((item_i.now - stamp) >= {{(TimeW-CountW){1'b0}}, interval});

  assign hazard_done = (cfg_i.count_limit != '0) &&
                       (state_i.hazard_cycles >= cfg_i.count_limit);

  assign mv_s = $signed({2'b00, item_i.millivolts});
  assign lo_s = {cfg_i.thresh_low[CountW-1], cfg_i.thresh_low};
  assign hi_s = {cfg_i.thresh_high[CountW-1], cfg_i.thresh_high};

  // N-press: a press outside the window restarts the count.
  always_comb begin
    edge_new      = state_i.edge_stamp;
    press_new     = state_i.press_total;
    pulse_new     = state_i.pulse_until;
    press_expired = ((item_i.now - state_i.edge_stamp) >
                     {{(TimeW-CountW){1'b0}}, cfg_i.window_time});
    if (rise) begin
      if (state_i.press_total == '0) begin
        edge_new = item_i.now;
      end else if (press_expired) begin
        press_new = '0;
        edge_new  = item_i.now;
      end
      press_new = press_new + CountW'(1);
      if (press_new >= cfg_i.count_limit) begin
        press_new = '0;
        pulse_new = item_i.now + {{(TimeW-CountW){1'b0}}, cfg_i.on_time};
      end
    end
    post_expired = ((item_i.now - edge_new) >
                    {{(TimeW-CountW){1'b0}}, cfg_i.window_time});
    if (press_new != '0 && post_expired) begin
      press_new = '0;
    end
  end

  always_comb begin
    state_o             = state_i;
    state_o.flash_stamp = stamp;
    state_o.started     = 1'b1;
    level_o             = 1'b0;
    case (cfg_i.mode)
      MODE_DIRECT:     level_o = s0;
      MODE_DIRECT_INV: level_o = ~s0;
      MODE_NOT:        level_o = ~s0;
      MODE_AND:        level_o = all_set;
      MODE_OR:         level_o = any_set;
      MODE_NAND:       level_o = ~all_set;
      MODE_NOR:        level_o = ~any_set;
      MODE_XOR:        level_o = s0 ^ item_i.second_source;
      MODE_TOGGLE: begin
        state_o.latch       = state_i.latch ^ rise;
        state_o.prev_source = s0;
        level_o             = state_o.latch;
      end
      MODE_SR_LATCH: begin
        if (item_i.second_source) begin
          state_o.latch = 1'b0;
        end else if (rise) begin
          state_o.latch = 1'b1;
        end
        state_o.prev_source = s0;
        level_o             = state_o.latch;
      end
      MODE_FLASHER: begin
        if (flash_adv) begin
          state_o.flash_on    = ~state_i.flash_on;
          state_o.flash_stamp = item_i.now;
        end
        level_o = state_o.flash_on;
      end
      MODE_HAZARD: begin
        if (!hazard_done) begin
          if (flash_adv) begin
            state_o.flash_on    = ~state_i.flash_on;
            state_o.flash_stamp = item_i.now;
            // Count completed cycles at each on-to-off change.
            if (state_i.flash_on && state_i.hazard_cycles != '1) begin
              state_o.hazard_cycles = state_i.hazard_cycles + CountW'(1);
            end
          end
          level_o = state_o.flash_on;
        end
      end
      MODE_THRESH, MODE_THRESH_INV: begin
        if (item_i.sample_ok) begin
          level_o = (mv_s > lo_s);
          if (cfg_i.mode == MODE_THRESH_INV) begin
            level_o = ~level_o;
          end
        end
      end
      MODE_HYSTERESIS: begin
        if (item_i.sample_ok) begin
          if (mv_s > hi_s) begin
            state_o.latch = 1'b1;
          end else if (mv_s < lo_s) begin
            state_o.latch = 1'b0;
          end
          level_o = state_o.latch;
        end
      end
      MODE_WATCHDOG: begin
        if (s0 != state_i.prev_source) begin
          state_o.prev_source = s0;
          state_o.edge_stamp  = item_i.now;
        end
        level_o = (cfg_i.window_time == '0) ||
                  ((item_i.now - state_o.edge_stamp) <
                   {{(TimeW-CountW){1'b0}}, cfg_i.window_time});
      end
      MODE_NPRESS: begin
        state_o.edge_stamp  = edge_new;
        state_o.press_total = press_new;
        state_o.pulse_until = pulse_new;
        state_o.prev_source = s0;
        level_o             = (item_i.now < pulse_new);
      end
      default: level_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/programmable_logic_rule_cell.sv =====
// Top level of the programmable logic rule cell: handshakes, registers and state.
//
// One rule cell of a power distribution output, evaluated once per timer tick.
// The input channel (in_valid_i/in_ready_o) carries one tick: the tick count,
// the source bits, the second source, the millivolt sample and its valid flag.
// The output channel (out_valid_o/out_ready_i) returns exactly one level per
// tick, in order. The configuration channel (cfg_valid_i/cfg_ready_o) writes
// one register per transfer by index; it is always ready and must only be
// used while no tick is in flight.
// Each tick is captured in an input register, evaluated by the rule logic and
// written to the output register, which drives out_valid_o and level_o.
// The rule state is updated as the tick moves into the output register, so
// one tick per cycle is sustained while the receiver takes results.
// When the receiver stalls, the output register holds its level, the input
// register holds the next tick, and in_ready_o drops until the output drains.
// Reset empties both registers and clears the rule state and the configuration
// (mode reads as output always low, source count one, times and thresholds zero).
`default_nettype none

module programmable_logic_rule_cell
  import plrc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CfgIndexW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]    cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [TimeW-1:0]       now_i,
  input  wire logic [NUM_SOURCES-1:0] sources_i,
  input  wire logic                   second_source_i,
  input  wire logic [MvW-1:0]         millivolts_i,
  input  wire logic                   sample_ok_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic                        level_o
);

  plrc_cfg_t   cfg_q;
  plrc_state_t state_q, state_d;
  plrc_item_t  item_q;
  logic        item_valid_q;
  logic        out_valid_q;
  logic        level_q, level_d;
  logic        advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= MODE_OFF;
      cfg_q.source_count <= 4'd1;
      cfg_q.on_time      <= '0;
      cfg_q.off_time     <= '0;
      cfg_q.window_time  <= '0;
      cfg_q.count_limit  <= '0;
      cfg_q.thresh_low   <= '0;
      cfg_q.thresh_high  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MODE:         cfg_q.mode         <= cfg_data_i[4:0];
        CFG_SOURCE_COUNT: cfg_q.source_count <= cfg_data_i[3:0];
        CFG_ON_TIME:      cfg_q.on_time      <= cfg_data_i;
        CFG_OFF_TIME:     cfg_q.off_time     <= cfg_data_i;
        CFG_WINDOW_TIME:  cfg_q.window_time  <= cfg_data_i;
        CFG_COUNT_LIMIT:  cfg_q.count_limit  <= cfg_data_i;
        CFG_THRESH_LOW:   cfg_q.thresh_low   <= cfg_data_i;
        CFG_THRESH_HIGH:  cfg_q.thresh_high  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A tick moves on when the output register is empty or being emptied.
  assign advance    = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.now           <= now_i;
      item_q.sources       <= sources_i;
      item_q.second_source <= second_source_i;
      item_q.millivolts    <= millivolts_i;
      item_q.sample_ok     <= sample_ok_i;
    end
  end

  plrc_eval u_eval (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (state_d),
    .level_o (level_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
      level_q     <= 1'b0;
    end else begin
      if (advance) begin
        state_q     <= state_d;
        level_q     <= level_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;

endmodule

`default_nettype wire
